// ===== rtl/core/pidfd_pkg.sv =====
// Package for the filtered-derivative PID block: types, codes and sizes.
// No dependencies; every other file of the block imports it.
package pidfd_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned OPND_W   = DATA_W + 1;      // multiplier operand
    localparam int unsigned PROD_W   = 2 * OPND_W;      // full product / wide sums
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned NUM_W    = DATA_W + FRAC_W; // divider dividend
    localparam int unsigned DEF_DIV_W = DATA_W;         // default divisor width

    typedef enum logic [CMD_W-1:0] {
        CMD_ERR_DIFF   = 2'd0,
        CMD_ERR_DIRECT = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 4'd0,
        REG_GAIN_I    = 4'd1,
        REG_GAIN_D    = 4'd2,
        REG_INT_FLOOR = 4'd3,
        REG_INT_CEIL  = 4'd4,
        REG_OUT_FLOOR = 4'd5,
        REG_OUT_CEIL  = 4'd6,
        REG_WEIGHT    = 4'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INT_MUL,
        S_INT_ADD,
        S_DIV,
        S_FLT_MUL,
        S_FLT_ADD,
        S_DRV_P,
        S_DRV_I,
        S_DRV_D,
        S_DRV_SUM,
        S_DRV_CLAMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/pidfd_ifs.sv =====
// Valid/ready channel interfaces for update words and drive words.
// Depends on pidfd_pkg.
interface pidfd_in_if
    import pidfd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] error_value;
    logic [DATA_W-1:0]        time_step;

    modport source (output valid, cmd, setpoint, measured, error_value, time_step,
                    input ready);
    modport sink   (input valid, cmd, setpoint, measured, error_value, time_step,
                    output ready);
endinterface

interface pidfd_out_if
    import pidfd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

// ===== rtl/core/pidfd_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on pidfd_pkg.
module pidfd_mul
    import pidfd_pkg::*;
(
    input  logic                     clk,
    input  logic signed [OPND_W-1:0] a,
    input  logic signed [OPND_W-1:0] b,
    output logic signed [PROD_W-1:0] prod
);
    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

// ===== rtl/core/pidfd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pidfd_pkg.
module pidfd_div
    import pidfd_pkg::*;
#(
    parameter int unsigned NW = NUM_W,
    parameter int unsigned DW = DEF_DIV_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_ctrl_t     ctrl,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output div_stat_t     stat,
    output logic [NW-1:0] quo
);
    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    q_reg, q_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], q_reg[NW-1]};
        if (ctrl.start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (ctrl.start)
        begin
            den_reg <= den;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;
endmodule

// ===== rtl/core/pid_filtered_derivative_top.sv =====
// Top level of the filtered-derivative PID controller: config registers,
// sequencer and state. Depends on pidfd_pkg, pidfd_ifs, pidfd_mul, pidfd_div.
//
// Channel   Dir  Word contents
// in_ch     in   cmd, setpoint, measured, error_value, time_step
// out_ch    out  drive
// cfg_*     in   write enable, register index, write data (no read-back)
//
// Order: an update takes the integral step, then, if the derivative filter
// runs, the slope in the 48-bit divider and the filter step, then the P, I
// and D products, their sum and the clamp, before it presents its drive word.
// A zero-step update presents the held drive word in the next cycle; clear and
// unused commands leave in_ch ready again on the next cycle.
// All products go through one registered 33x33 multiplier, in turn.
// Reset clears config and controller state. in_ch is ready only when idle;
// a waiting drive word holds until out_ch takes it.
module pid_filtered_derivative_top
    import pidfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidfd_in_if.sink             in_ch,
    pidfd_out_if.source          out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);
    localparam int unsigned DIV_W = DEF_DIV_W;   // divisor is the full time step

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sh8000_0000);

    // saturate a wide value to 32 bit signed
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX)
            r = S32_MAX[DATA_W-1:0];
        else if (v < S32_MIN)
            r = S32_MIN[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // ceiling tested first; with crossed bounds, values above it give the ceiling, others the floor
    function automatic logic signed [DATA_W-1:0] clamp(input logic signed [PROD_W-1:0] v,
                                                       input logic signed [DATA_W-1:0] lo,
                                                       input logic signed [DATA_W-1:0] hi);
        logic signed [DATA_W-1:0] r;
        if (v > PROD_W'(hi))
            r = hi;
        else if (v < PROD_W'(lo))
            r = lo;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // configuration
    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DATA_W-1:0] int_floor_reg, int_ceil_reg, out_floor_reg, out_ceil_reg;
    logic [WEIGHT_W-1:0]      weight_reg;

    // controller state
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] integral_reg, integral_next;
    logic signed [DATA_W-1:0] prior_reg, prior_next;
    logic signed [DATA_W-1:0] smooth_reg, smooth_next;
    logic signed [DATA_W-1:0] held_reg, held_next;
    logic                     have_prior_reg, have_prior_next;

    // per-update working registers
    logic signed [DATA_W-1:0] err_reg;
    logic [DIV_W-1:0]         dt_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] slope_reg;
    logic signed [PROD_W-1:0] acc_reg, acc_next;

    // shared units
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_q;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;
    logic [NUM_W-1:0]         div_num;
    logic [NUM_W-1:0]         div_quo;

    logic                     in_fire;
    logic signed [DATA_W:0]   raw_diff;
    logic signed [DATA_W-1:0] err_in;
    logic signed [DATA_W:0]   slope_diff;
    logic [DATA_W:0]          slope_mag;
    logic signed [NUM_W:0]    quo_signed;
    logic                     filter_on;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign prod_q   = prod >>> FRAC_W;                 // floor of Q16.16 product
    assign raw_diff = (DATA_W+1)'(in_ch.setpoint) - (DATA_W+1)'(in_ch.measured);
    assign err_in   = (cmd_t'(in_ch.cmd) == CMD_ERR_DIFF)
                      ? sat32(PROD_W'(raw_diff)) : in_ch.error_value;

    // derivative: |err - prior| << 16 over dt, sign restored afterwards
    assign slope_diff = (DATA_W+1)'(err_reg) - (DATA_W+1)'(prior_reg);
    assign slope_mag  = slope_diff[DATA_W] ? -slope_diff : slope_diff;
    assign div_num    = {slope_mag[DATA_W-1:0], FRAC_W'(0)};
    assign quo_signed = neg_reg ? -{1'b0, div_quo} : {1'b0, div_quo};
    assign filter_on  = have_prior_reg && (weight_reg != '0);

    pidfd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pidfd_div #(
        .NW (NUM_W),
        .DW (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (dt_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd_t'(in_ch.cmd) inside {CMD_ERR_DIFF, CMD_ERR_DIRECT})
                        state_next = (in_ch.time_step == '0) ? S_OUT : S_INT_MUL;
                end
            end
            S_INT_MUL:   state_next = S_INT_ADD;
            S_INT_ADD:   state_next = filter_on ? S_DIV : S_DRV_P;
            S_DIV:       state_next = div_stat.done ? S_FLT_MUL : S_DIV;
            S_FLT_MUL:   state_next = S_FLT_ADD;
            S_FLT_ADD:   state_next = S_DRV_P;
            S_DRV_P:     state_next = S_DRV_I;
            S_DRV_I:     state_next = S_DRV_D;
            S_DRV_D:     state_next = S_DRV_SUM;
            S_DRV_SUM:   state_next = S_DRV_CLAMP;
            S_DRV_CLAMP: state_next = S_OUT;
            S_OUT:       state_next = out_ch.ready ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshakes, multiplier operands, divider start
    always_comb
    begin
        in_ch.ready    = (state_reg == S_IDLE);
        out_ch.valid   = (state_reg == S_OUT);
        div_ctrl.start = (state_reg == S_INT_ADD) && filter_on;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            S_INT_MUL:
            begin
                mul_a = OPND_W'(err_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            S_FLT_MUL:
            begin
                mul_a = $signed({(OPND_W-WEIGHT_W)'(0), weight_reg});
                mul_b = (DATA_W+1)'(slope_reg) - (DATA_W+1)'(smooth_reg);
            end
            S_DRV_P:
            begin
                mul_a = OPND_W'(gain_p_reg);
                mul_b = OPND_W'(err_reg);
            end
            S_DRV_I:
            begin
                mul_a = OPND_W'(gain_i_reg);
                mul_b = OPND_W'(integral_reg);
            end
            S_DRV_D:
            begin
                mul_a = OPND_W'(gain_d_reg);
                mul_b = OPND_W'(smooth_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign out_ch.drive = held_reg;

    // state datapath
    always_comb
    begin
        integral_next   = integral_reg;
        prior_next      = prior_reg;
        smooth_next     = smooth_reg;
        held_next       = held_reg;
        have_prior_next = have_prior_reg;
        acc_next        = acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd_t'(in_ch.cmd) == CMD_CLEAR))
                begin
                    integral_next   = '0;
                    prior_next      = '0;
                    smooth_next     = '0;
                    held_next       = '0;
                    have_prior_next = 1'b0;
                end
            end
            S_INT_ADD:
            begin
                integral_next   = clamp(PROD_W'(integral_reg) + prod_q,
                                        int_floor_reg, int_ceil_reg);
                have_prior_next = 1'b1;
            end
            S_FLT_ADD:   smooth_next = sat32(PROD_W'(smooth_reg) + prod_q);
            S_DRV_P:     prior_next  = err_reg;
            S_DRV_I:     acc_next    = prod;
            S_DRV_D:     acc_next    = acc_reg + prod;
            S_DRV_SUM:   acc_next    = acc_reg + prod;
            S_DRV_CLAMP: held_next   = clamp(acc_reg >>> FRAC_W, out_floor_reg, out_ceil_reg);
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            integral_reg   <= '0;
            prior_reg      <= '0;
            smooth_reg     <= '0;
            held_reg       <= '0;
            have_prior_reg <= 1'b0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            int_floor_reg  <= '0;
            int_ceil_reg   <= '0;
            out_floor_reg  <= '0;
            out_ceil_reg   <= '0;
            weight_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            integral_reg   <= integral_next;
            prior_reg      <= prior_next;
            smooth_reg     <= smooth_next;
            held_reg       <= held_next;
            have_prior_reg <= have_prior_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_GAIN_P:    gain_p_reg    <= cfg_data;
                    REG_GAIN_I:    gain_i_reg    <= cfg_data;
                    REG_GAIN_D:    gain_d_reg    <= cfg_data;
                    REG_INT_FLOOR: int_floor_reg <= cfg_data;
                    REG_INT_CEIL:  int_ceil_reg  <= cfg_data;
                    REG_OUT_FLOOR: out_floor_reg <= cfg_data;
                    REG_OUT_CEIL:  out_ceil_reg  <= cfg_data;
                    REG_WEIGHT:    weight_reg    <= cfg_data[WEIGHT_W-1:0];
                    default:       weight_reg    <= weight_reg;   // unmapped index
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_fire)
        begin
            err_reg <= err_in;
            dt_reg  <= in_ch.time_step[DIV_W-1:0];
        end
        if (div_ctrl.start)
        begin
            neg_reg <= slope_diff[DATA_W];
        end
        if (div_stat.done)
        begin
            slope_reg <= sat32(PROD_W'(quo_signed));
        end
    end
endmodule
